// File: rtl/psu_pkg.sv
`timescale 1ns / 1ps

package psu_pkg;

    // fixed field widths
    localparam int BYTE_W        = 8;
    localparam int BPP_W         = 3;
    localparam int ROW_BYTES_W   = 14;
    localparam int IMAGE_ROWS_W  = 16;

    // configuration channel
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    // default sizing
    localparam int DEF_MAX_ROW_BYTES   = 8192;
    localparam int DEF_MAX_PIXEL_BYTES = 4;

    // register reset values
    localparam logic [BPP_W-1:0]        RST_BPP        = BPP_W'(4);
    localparam logic [ROW_BYTES_W-1:0]  RST_ROW_BYTES  = ROW_BYTES_W'(8192);
    localparam logic [IMAGE_ROWS_W-1:0] RST_IMAGE_ROWS = IMAGE_ROWS_W'(1);

endpackage

// File: rtl/psu_if.sv
`timescale 1ns / 1ps

// filtered stream, one byte per beat
interface psu_in_if import psu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// reconstructed bytes with row/image markers
interface psu_out_if import psu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pixel_byte;
    logic              last_in_row;
    logic              last_in_image;

    modport source (output valid, output pixel_byte, output last_in_row,
                    output last_in_image, input ready);
    modport sink   (input valid, input pixel_byte, input last_in_row,
                    input last_in_image, output ready);
endinterface

// register writes
interface psu_cfg_if import psu_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/png_scanline_unfilter_top.sv
`timescale 1ns / 1ps

// Channel   Modport  Payload                                      Beat moves
// stream    sink     data_byte[7:0]                               filter type or data byte
// pixels    source   pixel_byte[7:0], last_in_row, last_in_image  one rebuilt byte
// cfg       sink     index[1:0], data[15:0]                       one register write
//
// One byte per cycle while pixels.ready is high. An accepted data byte is
// rebuilt from the input stage (line buffer read launched at accept) and moves
// to the output register. A filter-type byte takes one beat and gives nothing.
// Reset clears control, counters, config and the left/upper-left history; the
// line buffer is not cleared (only rows already written are ever read).
// Stalls: output register holds; the input stage holds; stream.ready drops only
// while both are full and pixels.ready is low. cfg.ready is always high.

module png_scanline_unfilter_top import psu_pkg::*; #(
    parameter int MAX_ROW_BYTES   = DEF_MAX_ROW_BYTES,
    parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES
) (
    input  logic      clk,
    input  logic      rst_n,
    psu_in_if.sink    stream,
    psu_out_if.source pixels,
    psu_cfg_if.sink   cfg
);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BPP        = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = CFG_IDX_W'(2);

    // filter types
    localparam logic [BYTE_W-1:0] FILT_NONE  = BYTE_W'(0);
    localparam logic [BYTE_W-1:0] FILT_SUB   = BYTE_W'(1);
    localparam logic [BYTE_W-1:0] FILT_UP    = BYTE_W'(2);
    localparam logic [BYTE_W-1:0] FILT_AVG   = BYTE_W'(3);
    localparam logic [BYTE_W-1:0] FILT_PAETH = BYTE_W'(4);

    localparam int COL_W  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int CNT_W  = $clog2(MAX_ROW_BYTES + 1);
    localparam int LEN_W  = (CNT_W > ROW_BYTES_W) ? CNT_W : ROW_BYTES_W;
    localparam int SLOT_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int PBW    = $clog2(MAX_PIXEL_BYTES + 1);
    localparam int PW     = (PBW > BPP_W) ? PBW : BPP_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [BPP_W-1:0]        bpp_reg;
    logic [ROW_BYTES_W-1:0]  row_bytes_reg;
    logic [IMAGE_ROWS_W-1:0] image_rows_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg        <= RST_BPP;
            row_bytes_reg  <= RST_ROW_BYTES;
            image_rows_reg <= RST_IMAGE_ROWS;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_BPP:        bpp_reg        <= cfg.data[BPP_W-1:0];
                REG_ROW_BYTES:  row_bytes_reg  <= cfg.data[ROW_BYTES_W-1:0];
                REG_IMAGE_ROWS: image_rows_reg <= cfg.data[IMAGE_ROWS_W-1:0];
                default:        ;
            endcase
        end
    end

    // clamped register values
    logic [PW-1:0]           bpp_eff;
    logic [LEN_W-1:0]        rb_eff;
    logic [IMAGE_ROWS_W-1:0] rows_eff;

    always_comb
    begin
        if (bpp_reg == '0)
            bpp_eff = PW'(1);
        else if (PW'(bpp_reg) > PW'(MAX_PIXEL_BYTES))
            bpp_eff = PW'(MAX_PIXEL_BYTES);
        else
            bpp_eff = PW'(bpp_reg);

        if (row_bytes_reg == '0)
            rb_eff = LEN_W'(1);
        else if (LEN_W'(row_bytes_reg) > LEN_W'(MAX_ROW_BYTES))
            rb_eff = LEN_W'(MAX_ROW_BYTES);
        else
            rb_eff = LEN_W'(row_bytes_reg);

        rows_eff = (image_rows_reg == '0) ? IMAGE_ROWS_W'(1) : image_rows_reg;
    end

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic a_valid_reg;
    logic o_valid_reg;
    logic advance;
    logic accept;

    assign advance      = a_valid_reg && (!o_valid_reg || pixels.ready);
    assign stream.ready = !a_valid_reg || advance;
    assign accept       = stream.valid && stream.ready;

    // ------------------------------------------------------------------
    // row tracking, done at accept time
    // ------------------------------------------------------------------
    logic                    awaiting_reg;
    logic [BYTE_W-1:0]       filter_reg;
    logic [COL_W-1:0]        col_reg;
    logic [IMAGE_ROWS_W-1:0] row_reg;
    // lane k holds col mod (k+1), so any bytes-per-pixel setting has its slot
    logic [SLOT_W-1:0]       lane_reg [MAX_PIXEL_BYTES];
    logic [SLOT_W-1:0]       lane_next [MAX_PIXEL_BYTES];

    logic [LEN_W-1:0]        col_plus1;
    logic [IMAGE_ROWS_W:0]   row_plus1;
    logic                    end_row;
    logic                    end_image;
    logic [COL_W-1:0]        col_next;
    logic [IMAGE_ROWS_W-1:0] row_next;
    logic [SLOT_W-1:0]       slot;
    logic                    has_left;
    logic                    take_data;

    assign col_plus1 = LEN_W'(col_reg) + LEN_W'(1);
    assign row_plus1 = {1'b0, row_reg} + (IMAGE_ROWS_W+1)'(1);
    assign end_row   = (col_plus1 >= rb_eff);
    assign end_image = end_row && (row_plus1 >= {1'b0, rows_eff});
    assign col_next  = end_row ? '0 : COL_W'(col_plus1);
    assign row_next  = end_image ? '0 : row_plus1[IMAGE_ROWS_W-1:0];
    assign slot      = lane_reg[SLOT_W'(bpp_eff - PW'(1))];
    assign has_left  = (LEN_W'(col_reg) >= LEN_W'(bpp_eff));
    assign take_data = accept && !awaiting_reg;

    always_comb
    begin
        for (int k = 0; k < MAX_PIXEL_BYTES; k++)
        begin
            if (end_row || lane_reg[k] == SLOT_W'(k))
                lane_next[k] = '0;
            else
                lane_next[k] = lane_reg[k] + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b1;
            filter_reg   <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            for (int k = 0; k < MAX_PIXEL_BYTES; k++)
            begin
                lane_reg[k] <= '0;
            end
        end
        else if (accept)
        begin
            if (awaiting_reg)
            begin
                filter_reg   <= stream.data_byte;
                awaiting_reg <= 1'b0;
                col_reg      <= '0;
                for (int k = 0; k < MAX_PIXEL_BYTES; k++)
                begin
                    lane_reg[k] <= '0;
                end
            end
            else
            begin
                col_reg <= col_next;
                for (int k = 0; k < MAX_PIXEL_BYTES; k++)
                begin
                    lane_reg[k] <= lane_next[k];
                end
                if (end_row)
                begin
                    awaiting_reg <= 1'b1;
                    row_reg      <= row_next;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // line buffer: read launched at accept, written when the byte is rebuilt
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] line_mem [MAX_ROW_BYTES];
    logic [BYTE_W-1:0] up_rd_reg;
    logic [BYTE_W-1:0] recon;

    // input stage
    logic [BYTE_W-1:0] a_raw_reg;
    logic [BYTE_W-1:0] a_filter_reg;
    logic [COL_W-1:0]  a_col_reg;
    logic [SLOT_W-1:0] a_slot_reg;
    logic              a_has_left_reg;
    logic              a_has_up_reg;
    logic              a_end_row_reg;
    logic              a_end_image_reg;

    always_ff @(posedge clk)
    begin
        if (take_data)
            up_rd_reg <= line_mem[col_reg];
        if (advance)
            line_mem[a_col_reg] <= recon;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (take_data)
            a_valid_reg <= 1'b1;
        else if (advance)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take_data)
        begin
            a_raw_reg       <= stream.data_byte;
            a_filter_reg    <= filter_reg;
            a_col_reg       <= col_reg;
            a_slot_reg      <= slot;
            a_has_left_reg  <= has_left;
            a_has_up_reg    <= (row_reg != '0);
            a_end_row_reg   <= end_row;
            a_end_image_reg <= end_image;
        end
    end

    // ------------------------------------------------------------------
    // neighbours and predictor
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] left_hist_reg  [MAX_PIXEL_BYTES];
    logic [BYTE_W-1:0] upper_hist_reg [MAX_PIXEL_BYTES];

    logic [BYTE_W-1:0] nb_a;
    logic [BYTE_W-1:0] nb_b;
    logic [BYTE_W-1:0] nb_c;
    logic [BYTE_W:0]   avg_sum;
    logic signed [BYTE_W+1:0] pa;
    logic signed [BYTE_W+1:0] pb;
    logic signed [BYTE_W+1:0] pc;
    logic [BYTE_W-1:0] paeth;
    logic [BYTE_W-1:0] pred;

    assign nb_a    = a_has_left_reg ? left_hist_reg[a_slot_reg]  : '0;
    assign nb_c    = a_has_left_reg ? upper_hist_reg[a_slot_reg] : '0;
    assign nb_b    = a_has_up_reg   ? up_rd_reg : '0;
    assign avg_sum = {1'b0, nb_a} + {1'b0, nb_b};

    always_comb
    begin
        // distances to p = a + b - c, taken as |b-c|, |a-c|, |a+b-2c|
        pa = $signed({2'b00, nb_b}) - $signed({2'b00, nb_c});
        pb = $signed({2'b00, nb_a}) - $signed({2'b00, nb_c});
        pc = pa + pb;
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        if (pa <= pb && pa <= pc)
            paeth = nb_a;
        else if (pb <= pc)
            paeth = nb_b;
        else
            paeth = nb_c;

        case (a_filter_reg)
            FILT_NONE:  pred = '0;
            FILT_SUB:   pred = nb_a;
            FILT_UP:    pred = nb_b;
            FILT_AVG:   pred = avg_sum[BYTE_W:1];
            FILT_PAETH: pred = paeth;
            default:    pred = '0;   // unknown types pass through
        endcase
    end

    assign recon = a_raw_reg + pred;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PIXEL_BYTES; k++)
            begin
                left_hist_reg[k]  <= '0;
                upper_hist_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            left_hist_reg[a_slot_reg]  <= recon;
            upper_hist_reg[a_slot_reg] <= nb_b;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] o_pixel_reg;
    logic              o_last_row_reg;
    logic              o_last_image_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (advance)
            o_valid_reg <= 1'b1;
        else if (pixels.ready)
            o_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            o_pixel_reg      <= recon;
            o_last_row_reg   <= a_end_row_reg;
            o_last_image_reg <= a_end_image_reg;
        end
    end

    assign pixels.valid         = o_valid_reg;
    assign pixels.pixel_byte    = o_pixel_reg;
    assign pixels.last_in_row   = o_last_row_reg;
    assign pixels.last_in_image = o_last_image_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_image_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        pixels.valid |-> (!pixels.last_in_image || pixels.last_in_row))
        else $error("image end without row end");

    a_filter_wait_at_col0: assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_reg |-> (col_reg == '0))
        else $error("waiting for filter byte with nonzero column");

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (o_valid_reg && $past(a_end_row_reg) == o_last_row_reg))
        else $error("rebuilt byte lost on the way to the output register");

endmodule

// File: bench/tb_png_scanline_unfilter_top.sv
`timescale 1ns / 1ps

// Bench for the PNG scanline unfilter. A behavioural copy of the reconstruction
// runs alongside the block; every rebuilt byte is compared with the oldest
// outstanding prediction, field by field.

module tb_png_scanline_unfilter_top;
    import psu_pkg::*;

    // ------------------------------------------------------------------
    // Codes
    // ------------------------------------------------------------------
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BPP        = 2'd0,
        REG_ROW_BYTES  = 2'd1,
        REG_IMAGE_ROWS = 2'd2
    } reg_idx_t;

    typedef enum logic [BYTE_W-1:0] {
        FT_NONE  = 8'd0,
        FT_SUB   = 8'd1,
        FT_UP    = 8'd2,
        FT_AVG   = 8'd3,
        FT_PAETH = 8'd4
    } filter_t;

    // any type above Paeth passes data through untouched
    localparam logic [BYTE_W-1:0] FT_UNKNOWN = 8'hFF;

    typedef enum logic {STEP_BYTE, STEP_CFG} step_op_t;

    // ------------------------------------------------------------------
    // Timing knobs
    // ------------------------------------------------------------------
    localparam int RANDOM_BYTES  = 1250;
    localparam int DRAIN_LIMIT   = 5000;  // cycles to wait for stragglers
    localparam int SETTLE_CYCLES = 6;     // covers a filter-type beat in flight
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off

    // ------------------------------------------------------------------
    // One expected output beat
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [BYTE_W-1:0] pixel;
        logic              last_row;
        logic              last_image;
    } rebuilt_t;

    // ------------------------------------------------------------------
    // Directed steps: register write or stream beat; pix/lr/li typed in
    // only when 'typed' is set, otherwise the predictor supplies them.
    // ------------------------------------------------------------------
    typedef struct packed {
        step_op_t          op;
        reg_idx_t          idx;
        logic [15:0]       val;
        logic              typed;
        logic [BYTE_W-1:0] pix;
        logic              lr;
        logic              li;
    } dir_step_t;

    localparam dir_step_t DIRECTED [33] = '{
        // straight after reset: bpp 4, 8192-byte rows, one-row images
        '{STEP_BYTE, REG_BPP,        16'(FT_NONE),  1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_BYTE, REG_BPP,        16'h00A5,      1'b1, 8'hA5, 1'b0, 1'b0},
        // row length cut mid-row: the next byte closes row and image
        '{STEP_CFG,  REG_ROW_BYTES,  16'd2,         1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_BYTE, REG_BPP,        16'h003C,      1'b1, 8'h3C, 1'b1, 1'b1},
        // bpp 1, 3-byte rows, two-row image: Sub then Up at the byte extremes
        '{STEP_CFG,  REG_BPP,        16'd1,         1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_CFG,  REG_ROW_BYTES,  16'd3,         1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_CFG,  REG_IMAGE_ROWS, 16'd2,         1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_BYTE, REG_BPP,        16'(FT_SUB),   1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_BYTE, REG_BPP,        16'h00FF,      1'b1, 8'hFF, 1'b0, 1'b0},
        '{STEP_BYTE, REG_BPP,        16'h0001,      1'b1, 8'h00, 1'b0, 1'b0},
        '{STEP_BYTE, REG_BPP,        16'h00FF,      1'b1, 8'hFF, 1'b1, 1'b0},
        '{STEP_BYTE, REG_BPP,        16'(FT_UP),    1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_BYTE, REG_BPP,        16'h0001,      1'b1, 8'h00, 1'b0, 1'b0},
        '{STEP_BYTE, REG_BPP,        16'h00FF,      1'b1, 8'hFF, 1'b0, 1'b0},
        '{STEP_BYTE, REG_BPP,        16'h0000,      1'b1, 8'hFF, 1'b1, 1'b1},
        // out-of-range registers: bpp 7 clamps to 4, zero rows/bytes act as 1
        '{STEP_CFG,  REG_BPP,        16'd7,         1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_CFG,  REG_ROW_BYTES,  16'd0,         1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_CFG,  REG_IMAGE_ROWS, 16'd0,         1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_BYTE, REG_BPP,        16'(FT_PAETH), 1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_BYTE, REG_BPP,        16'h00EE,      1'b1, 8'hEE, 1'b1, 1'b1},
        '{STEP_BYTE, REG_BPP,        16'(FT_UNKNOWN), 1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_BYTE, REG_BPP,        16'h0012,      1'b1, 8'h12, 1'b1, 1'b1},
        // bpp 0 taken as 1; Average row then Paeth row with real neighbours
        '{STEP_CFG,  REG_BPP,        16'd0,         1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_CFG,  REG_ROW_BYTES,  16'd3,         1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_CFG,  REG_IMAGE_ROWS, 16'd2,         1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_BYTE, REG_BPP,        16'(FT_AVG),   1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_BYTE, REG_BPP,        16'h0080,      1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_BYTE, REG_BPP,        16'h007F,      1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_BYTE, REG_BPP,        16'h0055,      1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_BYTE, REG_BPP,        16'(FT_PAETH), 1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_BYTE, REG_BPP,        16'h0010,      1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_BYTE, REG_BPP,        16'h00F0,      1'b0, 8'h00, 1'b0, 1'b0},
        '{STEP_BYTE, REG_BPP,        16'h0037,      1'b0, 8'h00, 1'b0, 1'b0}
    };

    // ------------------------------------------------------------------
    // Clock, reset, channels, DUT
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    psu_in_if  stream_if ();
    psu_out_if pixel_if ();
    psu_cfg_if cfg_if ();

    png_scanline_unfilter_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .pixels (pixel_if),
        .cfg    (cfg_if)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    rebuilt_t rebuilt_q [$];      // predicted beats, oldest first
    int       err_cnt      = 0;
    int       beat_cnt     = 0;
    int       send_idle_pct = 0;  // chance per beat of a sender gap cycle
    int       stall_pct     = 0;  // chance per cycle of receiver stall
    logic     hold_off      = 1'b0;

    // shadow registers, as written
    logic [BPP_W-1:0]        reg_bpp;
    logic [ROW_BYTES_W-1:0]  reg_row_bytes;
    logic [IMAGE_ROWS_W-1:0] reg_image_rows;

    // predictor state
    logic [BYTE_W-1:0] line_buf    [DEF_MAX_ROW_BYTES];
    logic [BYTE_W-1:0] left_hist   [DEF_MAX_PIXEL_BYTES];
    logic [BYTE_W-1:0] upleft_hist [DEF_MAX_PIXEL_BYTES];
    int                col_idx;
    int                row_idx;
    logic [BYTE_W-1:0] row_type;
    logic              awaiting_type;

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------
    task automatic report_error(input string msg);
        $display("%0t ns  beat %0d: %s", $realtime, beat_cnt, msg);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic clear_model();
        reg_bpp        = RST_BPP;
        reg_row_bytes  = RST_ROW_BYTES;
        reg_image_rows = RST_IMAGE_ROWS;
        for (int i = 0; i < DEF_MAX_PIXEL_BYTES; i++)
        begin
            left_hist[i]   = '0;
            upleft_hist[i] = '0;
        end
        col_idx       = 0;
        row_idx       = 0;
        row_type      = '0;
        awaiting_type = 1'b1;
    endtask

    function automatic logic [BYTE_W-1:0] paeth_pick(input logic [BYTE_W-1:0] a,
                                                     input logic [BYTE_W-1:0] b,
                                                     input logic [BYTE_W-1:0] c);
        int ia, ib, ic, p, da, db, dc;
        ia = a;
        ib = b;
        ic = c;
        p  = ia + ib - ic;
        da = (p >= ia) ? p - ia : ia - p;
        db = (p >= ib) ? p - ib : ib - p;
        dc = (p >= ic) ? p - ic : ic - p;
        if (da <= db && da <= dc)
            return a;
        else if (db <= dc)
            return b;
        else
            return c;
    endfunction

    // Consumes one stream byte; returns 1 with the rebuilt beat when it is data.
    function automatic logic unfilter_byte(input logic [BYTE_W-1:0] raw,
                                           output rebuilt_t res);
        int                bpp, rb, rows, col, slot;
        logic [BYTE_W-1:0] a, b, c, pred, recon;
        logic [BYTE_W:0]   sum;
        logic              end_row;
        bpp  = (reg_bpp == 0) ? 1 :
               (reg_bpp > DEF_MAX_PIXEL_BYTES) ? DEF_MAX_PIXEL_BYTES : int'(reg_bpp);
        rb   = (reg_row_bytes == 0) ? 1 :
               (reg_row_bytes > DEF_MAX_ROW_BYTES) ? DEF_MAX_ROW_BYTES
                                                   : int'(reg_row_bytes);
        rows = (reg_image_rows == 0) ? 1 : int'(reg_image_rows);
        res  = '0;

        if (awaiting_type)
        begin
            row_type      = raw;
            col_idx       = 0;
            awaiting_type = 1'b0;
            return 1'b0;
        end

        col  = (col_idx >= DEF_MAX_ROW_BYTES) ? DEF_MAX_ROW_BYTES - 1 : col_idx;
        slot = col % bpp;
        a = '0;
        b = '0;
        c = '0;
        if (row_idx > 0)
            b = line_buf[col];
        if (col >= bpp)
        begin
            a = left_hist[slot];
            c = upleft_hist[slot];
        end

        case (row_type)
            FT_SUB:   pred = a;
            FT_UP:    pred = b;
            FT_AVG:
            begin
                sum  = a + b;
                pred = sum[BYTE_W:1];
            end
            FT_PAETH: pred = paeth_pick(a, b, c);
            default:  pred = '0;
        endcase
        recon = raw + pred;

        left_hist[slot]   = recon;
        upleft_hist[slot] = b;
        line_buf[col]     = recon;

        end_row      = (col + 1 >= rb);
        res.pixel    = recon;
        res.last_row = end_row;
        if (end_row)
        begin
            awaiting_type = 1'b1;
            col_idx       = 0;
            if (row_idx + 1 >= rows)
            begin
                res.last_image = 1'b1;
                row_idx        = 0;
            end
            else
                row_idx = (row_idx + 1) & 16'hFFFF;
        end
        else
            col_idx = col + 1;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Leaves valid high; caller lowers it after the last write of a batch.
    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            REG_BPP:        reg_bpp        = val[BPP_W-1:0];
            REG_ROW_BYTES:  reg_row_bytes  = val[ROW_BYTES_W-1:0];
            REG_IMAGE_ROWS: reg_image_rows = val[IMAGE_ROWS_W-1:0];
            default: ;
        endcase
    endtask

    // One stream beat, with random gap cycles ahead of it.
    task automatic put_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            stream_if.valid <= 1'b0;
            @(posedge clk);
        end
        stream_if.valid     <= 1'b1;
        stream_if.data_byte <= b;
        @(posedge clk);
        while (!stream_if.ready)
            @(posedge clk);
    endtask

    // Wait for every predicted beat, then let a trailing filter-type beat settle.
    task automatic wait_drained();
        int waited;
        waited = 0;
        while (rebuilt_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (rebuilt_q.size() != 0)
        begin
            report_error($sformatf("%0d predicted beats never came out", rebuilt_q.size()));
            rebuilt_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 47; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 47; end
            default: begin send_idle_pct = 18; stall_pct = 18; end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Receiver: checks accepted beats, stalls at random or during hold-off
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rebuilt_t want;
        if (rst_n && pixel_if.valid && pixel_if.ready)
        begin
            beat_cnt++;
            if (rebuilt_q.size() == 0)
                report_error($sformatf("unexpected beat, pixel_byte %02h",
                                       pixel_if.pixel_byte));
            else
            begin
                want = rebuilt_q.pop_front();
                if (pixel_if.pixel_byte !== want.pixel)
                    report_error($sformatf("pixel_byte %02h, want %02h",
                                           pixel_if.pixel_byte, want.pixel));
                if (pixel_if.last_in_row !== want.last_row)
                    report_error($sformatf("last_in_row %b, want %b",
                                           pixel_if.last_in_row, want.last_row));
                if (pixel_if.last_in_image !== want.last_image)
                    report_error($sformatf("last_in_image %b, want %b",
                                           pixel_if.last_in_image, want.last_image));
            end
        end
        if (hold_off)
            pixel_if.ready <= 1'b0;
        else
            pixel_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly the five real filter types, now and then an unknown one; data bytes random, biased to 00 and FF.
    function automatic logic [BYTE_W-1:0] pick_byte();
        if (awaiting_type)
        begin
            if ($urandom_range(0, 9) != 0)
                return BYTE_W'($urandom_range(FT_NONE, FT_PAETH));
            return BYTE_W'($urandom_range(FT_PAETH + 1, 255));
        end
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic run_directed();
        dir_step_t st;
        rebuilt_t  res;
        logic      prev_byte;
        prev_byte = 1'b0;
        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            st = DIRECTED[i];
            if (st.op == STEP_CFG)
            begin
                // registers change only once the block has gone quiet
                if (prev_byte)
                begin
                    stream_if.valid <= 1'b0;
                    wait_drained();
                end
                write_reg(st.idx, st.val);
                prev_byte = 1'b0;
            end
            else
            begin
                if (!prev_byte)
                    cfg_if.valid <= 1'b0;
                if (unfilter_byte(st.val[BYTE_W-1:0], res))
                begin
                    if (st.typed)
                    begin
                        res.pixel      = st.pix;
                        res.last_row   = st.lr;
                        res.last_image = st.li;
                    end
                    rebuilt_q.push_back(res);
                end
                put_byte(st.val[BYTE_W-1:0]);
                prev_byte = 1'b1;
            end
        end
        stream_if.valid <= 1'b0;
        wait_drained();
    endtask

    task automatic run_phase(input int n_bytes);
        rebuilt_t          res;
        logic [BYTE_W-1:0] b;
        for (int k = 0; k < n_bytes; k++)
        begin
            b = pick_byte();
            if (unfilter_byte(b, res))
                rebuilt_q.push_back(res);
            put_byte(b);
        end
        stream_if.valid <= 1'b0;
        wait_drained();
    endtask

    // Random subset of registers, biased to small rows and the range edges.
    // Row length moves only on the first row of an image, so a later row
    // never reaches a line-buffer entry that its image has not written.
    task automatic shuffle_config();
        logic        wrote;
        logic [15:0] v;
        wrote = 1'b0;
        if ($urandom_range(0, 1))
        begin
            write_reg(REG_BPP, 16'($urandom_range(0, 7)));
            wrote = 1'b1;
        end
        if (row_idx == 0 && $urandom_range(0, 1))
        begin
            case ($urandom_range(0, 9))
                0:       v = 16'd0;
                1:       v = 16'd1;
                default: v = 16'($urandom_range(2, 20));
            endcase
            write_reg(REG_ROW_BYTES, v);
            wrote = 1'b1;
        end
        if ($urandom_range(0, 1))
        begin
            case ($urandom_range(0, 7))
                0:       v = 16'd0;
                1:       v = 16'hFFFF;
                2:       v = 16'd1;
                default: v = 16'($urandom_range(2, 6));
            endcase
            write_reg(REG_IMAGE_ROWS, v);
            wrote = 1'b1;
        end
        if (wrote)
            cfg_if.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int sent;
        int phase;
        int n;

        clear_model();
        rst_n               <= 1'b0;
        stream_if.valid     <= 1'b0;
        stream_if.data_byte <= '0;
        cfg_if.valid        <= 1'b0;
        cfg_if.index        <= REG_BPP;
        cfg_if.data         <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table first, with a steady pace on both sides.
        set_idling(0);
        run_directed();

        // Random phases: short rows, settings shuffled between phases, which
        // may fall mid-row or mid-image. Idling pattern rotates per phase.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_BYTES)
        begin
            set_idling(phase);
            shuffle_config();
            n = $urandom_range(20, 80);
            if (phase == 0)
            begin
                // back-pressure: receiver shut for a long stretch while the
                // sender keeps offering, so both stages fill and input stalls
                n = 120;
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        hold_off <= 1'b0;
                    end
                join_none
            end
            run_phase(n);
            sent += n;
            phase++;
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("tb_png_scanline_unfilter_top: clean");
        else
            $display("tb_png_scanline_unfilter_top: errors");
        $finish;
    end

    // Watchdog, well clear of the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("tb_png_scanline_unfilter_top: errors");
        $finish;
    end

endmodule
